### rtl/wsmr_pkg.sv
// Package for the word stream multiply-rotate hash unit.
// Holds the mixing constants, register indexes and the byte-order helper functions.
// It has no dependencies. The top level, the checker and the bench import it.
package wsmr_pkg;

   localparam int unsigned LEN_BITS     = 32;
   localparam int unsigned CSR_IDX_BITS = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SEED = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_SWAP = CSR_IDX_BITS'(1);

   localparam logic [63:0] MUL_A   = 64'h3C79AC492BA7B653;
   localparam logic [63:0] MUL_B   = 64'h1C69B3F74AC4AE35;
   localparam logic [63:0] MUL_C   = 64'hBEA225F9EB34556D;
   localparam logic [63:0] PRIME_Q = 64'hD1B92B09B92266DD;
   localparam logic [63:0] PRIME_R = 64'h9995988B72E0D285;
   localparam logic [63:0] PRIME_S = 64'h8FADF5E286E31587;
   localparam logic [63:0] PRIME_T = 64'hFCF8B405D3D0783B;

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned k);
      return (v << k) | (v >> (64 - k));
   endfunction

   function automatic logic [63:0] swap64(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = v[8*(7-i) +: 8];
      end
      return r;
   endfunction

   function automatic logic [63:0] group_prime(input logic [1:0] k);
      logic [63:0] p;
      case (k)
         2'd0: p = PRIME_Q;
         2'd1: p = PRIME_R;
         2'd2: p = PRIME_S;
         default: p = PRIME_T;
      endcase
      return p;
   endfunction

   // Assembles the last n bytes of a message, as read in the selected byte order.
   function automatic logic [63:0] tail_value(input logic [63:0] w, input logic [2:0] n,
                                              input logic swap);
      logic [63:0] v;
      logic [31:0] s32;
      s32 = {w[7:0], w[15:8], w[23:16], w[31:24]};
      if (!swap) begin
         for (int i = 0; i < 8; i++) begin
            v[8*i +: 8] = (i < int'(n)) ? w[8*i +: 8] : 8'h00;
         end
      end else begin
         case (n)
            3'd1: v = {56'h0, w[7:0]};
            3'd2: v = {48'h0, w[7:0], w[15:8]};
            3'd3: v = {40'h0, w[23:16], w[7:0], w[15:8]};
            3'd4: v = {32'h0, s32};
            3'd5: v = {24'h0, w[39:32], s32};
            3'd6: v = {16'h0, w[39:32], w[47:40], s32};
            3'd7: v = {8'h0, w[55:48], w[39:32], w[47:40], s32};
            default: v = 64'h0;
         endcase
      end
      return v;
   endfunction

   function automatic logic [63:0] hash_init(input logic [63:0] len, input logic [63:0] seed);
      return len ^ rotl64(len, 3) ^ rotl64(len, 47)
           ^ seed ^ rotl64(seed, 23) ^ rotl64(seed, 56);
   endfunction

endpackage

### rtl/wsmr_mul.sv
// Iterative 64 by 64 bit multiplier that keeps the low 64 bits of the product.
// It uses one 32 by 32 bit multiplier for the partial products LL, LH and HL in turn and accumulates them.
// It has no dependencies. The hash top level instantiates it.
module wsmr_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   localparam logic [1:0] PH_LL = 2'd0;
   localparam logic [1:0] PH_LH = 2'd1;
   localparam logic [1:0] PH_HL = 2'd2;

   logic [63:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [1:0]  phase_ff, phase_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] mx, my;
   logic [63:0] mp;

   always_comb begin
      case (phase_ff)
         PH_LL: begin
            mx = a_ff[31:0];
            my = b_ff[31:0];
         end
         PH_LH: begin
            mx = a_ff[31:0];
            my = b_ff[63:32];
         end
         default: begin
            mx = a_ff[63:32];
            my = b_ff[31:0];
         end
      endcase
      mp = {32'h0, mx} * {32'h0, my};
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         a_in     = op_a;
         b_in     = op_b;
         phase_in = PH_LL;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         case (phase_ff)
            PH_LL: begin
               acc_in   = mp;
               phase_in = PH_LH;
            end
            PH_LH: begin
               acc_in   = acc_ff + {mp[31:0], 32'h0};
               phase_in = PH_HL;
            end
            default: begin
               acc_in   = acc_ff + {mp[31:0], 32'h0};
               phase_in = PH_LL;
               busy_in  = 1'b0;
               done_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      if (reset) begin
         phase_ff <= PH_LL;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

### rtl/word_stream_multiply_rotate_hash64_unit.sv
// Top level of the word stream multiply-rotate 64-bit hash unit.
// It holds the message state, the sequencer and the result register, and uses wsmr_pkg
// and the shared multiplier wsmr_mul.
//
//   channel  direction  handshake                transaction
//   req_     in         req_valid / req_stall    one message word
//   rsp_     out        rsp_valid / rsp_stall    one finished hash
//   csr_     in         csr_valid / csr_ready    one register write
//
// Every multiply goes through the one shared unit. A word that is only gathered into a group
// needs no multiply. A whole or partial word is folded with its own multiplies, the word that
// closes a group of four folds the whole group, and the final mix adds multiplies of its own.
// req_stall stays high while the sequencer is busy. The result register lets the next
// message start while a finished hash is still stalled. Reset is synchronous and clears
// all control state and the seed and swap registers, but not the data registers.
module word_stream_multiply_rotate_hash64_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [63:0]                        req_data_word,
   input  logic                               req_first_word,
   input  logic [31:0]                        req_message_length,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [63:0]                        rsp_hash_value,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wsmr_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [63:0]                        csr_data
);
   import wsmr_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_GROUP  = 2'd1;
   localparam logic [1:0] MODE_FINAL  = 2'd2;

   logic [1:0]          state_ff, state_in, mode_ff, mode_in;
   logic [2:0]          step_ff, step_in, last_step;
   logic                go_ff, go_in, emit_ff, emit_in;
   logic [63:0]         hash_ff, hash_in, tmp_ff, tmp_in, word_ff, word_in;
   logic [63:0]         grp_ff [0:2];
   logic [63:0]         grp_in [0:2];
   logic [LEN_BITS-1:0] bl_ff, bl_in;
   logic [1:0]          pos_ff, pos_in;
   logic                half_ff, half_in;
   logic [63:0]         seed_ff, seed_in;
   logic                swap_ff, swap_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_hash_ff, rsp_hash_in;

   logic [63:0]         len_w, h0, xw, mul_a, mul_b, mul_p, r;
   logic [LEN_BITS-1:0] len_v, bl0, bl1;
   logic [1:0]          pos0, k;
   logic                blk0, half0, enter, ignore, empty, mul_done;

   always_comb begin
      len_w = {32'h0, req_message_length};
      len_v = len_w[LEN_BITS-1:0];
      bl0   = req_first_word ? len_v : bl_ff;
      blk0  = !req_first_word && ((pos_ff != 2'd0) || half_ff);
      h0    = req_first_word ? hash_init(64'(len_v), seed_ff) : hash_ff;
      pos0  = req_first_word ? 2'd0 : pos_ff;
      half0 = req_first_word ? 1'b0 : half_ff;
      empty = req_first_word && (len_v == '0);
      ignore = !req_first_word && !blk0 && (bl0 == '0);
      enter = !blk0 && (bl0 >= LEN_BITS'(64));
      bl1   = enter ? bl0 - LEN_BITS'(64) : bl0;
      xw    = swap_ff ? swap64(req_data_word) : req_data_word;
   end

   always_comb begin
      k = step_ff[2:1];
      case (mode_ff)
         MODE_SINGLE: begin
            mul_a = (step_ff == 3'd0) ? word_ff : tmp_ff;
            mul_b = MUL_C;
            last_step = 3'd2;
         end
         MODE_GROUP: begin
            if (step_ff[0]) begin
               mul_a = tmp_ff;
            end else begin
               case (k)
                  2'd0: mul_a = rotl64(grp_ff[0], 29) - grp_ff[2];
                  2'd1: mul_a = rotl64(grp_ff[1], 29) - word_ff;
                  2'd2: mul_a = rotl64(grp_ff[2], 29) - grp_ff[1];
                  default: mul_a = rotl64(word_ff, 29) - grp_ff[0];
               endcase
            end
            mul_b = group_prime(k);
            last_step = 3'd7;
         end
         MODE_FINAL: begin
            mul_a = (step_ff == 3'd0) ? (hash_ff ^ (hash_ff >> 27)) : tmp_ff;
            mul_b = (step_ff == 3'd0) ? MUL_A : MUL_B;
            last_step = 3'd1;
         end
         default: begin
            mul_a = 64'h0;
            mul_b = 64'h0;
            last_step = 3'd0;
         end
      endcase
   end

   wsmr_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (go_ff),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      go_in        = 1'b0;
      emit_in      = emit_ff;
      hash_in      = hash_ff;
      tmp_in       = tmp_ff;
      word_in      = word_ff;
      grp_in       = grp_ff;
      bl_in        = bl_ff;
      pos_in       = pos_ff;
      half_in      = half_ff;
      seed_in      = seed_ff;
      swap_in      = swap_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      r            = mul_p;

      if (csr_valid) begin
         case (csr_index)
            CSR_SEED: seed_in = csr_data;
            CSR_SWAP: swap_in = csr_data[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !ignore) begin
               hash_in = h0;
               bl_in   = bl1;
               pos_in  = pos0;
               half_in = half0;
               step_in = 3'd0;
               if (empty) begin
                  mode_in  = MODE_FINAL;
                  state_in = ST_RUN;
                  go_in    = 1'b1;
               end else if (blk0 || enter) begin
                  if (pos0 != 2'd3) begin
                     grp_in[pos0] = xw;
                     pos_in       = pos0 + 2'd1;
                  end else begin
                     word_in  = xw;
                     hash_in  = rotl64(h0, 39);
                     pos_in   = 2'd0;
                     half_in  = !half0;
                     emit_in  = half0 && (bl1 == '0);
                     mode_in  = MODE_GROUP;
                     state_in = ST_RUN;
                     go_in    = 1'b1;
                  end
               end else if (bl1 >= LEN_BITS'(8)) begin
                  word_in  = xw;
                  bl_in    = bl1 - LEN_BITS'(8);
                  emit_in  = (bl1 == LEN_BITS'(8));
                  mode_in  = MODE_SINGLE;
                  state_in = ST_RUN;
                  go_in    = 1'b1;
               end else begin
                  word_in  = tail_value(req_data_word, bl1[2:0], swap_ff);
                  bl_in    = '0;
                  emit_in  = 1'b1;
                  mode_in  = MODE_SINGLE;
                  state_in = ST_RUN;
                  go_in    = 1'b1;
               end
            end
         end
         ST_RUN: begin
            if (mul_done) begin
               case (mode_ff)
                  MODE_SINGLE: begin
                     if (step_ff == 3'd0) begin
                        tmp_in = r ^ (r >> 39);
                     end else if (step_ff == 3'd1) begin
                        tmp_in = hash_ff + r;
                     end else begin
                        hash_in = r;
                     end
                  end
                  MODE_GROUP: begin
                     if (step_ff[0]) begin
                        hash_in = r;
                     end else begin
                        tmp_in = hash_ff + r;
                     end
                  end
                  default: begin
                     tmp_in = (step_ff == 3'd0) ? (r ^ (r >> 33)) : (r ^ (r >> 27));
                  end
               endcase
               if (step_ff == last_step) begin
                  if (mode_ff == MODE_FINAL) begin
                     state_in = ST_EMIT;
                  end else if (emit_ff) begin
                     mode_in = MODE_FINAL;
                     step_in = 3'd0;
                     go_in   = 1'b1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  step_in = step_ff + 3'd1;
                  go_in   = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = tmp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      tmp_ff      <= tmp_in;
      word_ff     <= word_in;
      grp_ff      <= grp_in;
      rsp_hash_ff <= rsp_hash_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SINGLE;
         step_ff      <= 3'd0;
         go_ff        <= 1'b0;
         emit_ff      <= 1'b0;
         hash_ff      <= 64'h0;
         bl_ff        <= '0;
         pos_ff       <= 2'd0;
         half_ff      <= 1'b0;
         seed_ff      <= 64'h0;
         swap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         step_ff      <= step_in;
         go_ff        <= go_in;
         emit_ff      <= emit_in;
         hash_ff      <= hash_in;
         bl_ff        <= bl_in;
         pos_ff       <= pos_in;
         half_ff      <= half_in;
         seed_ff      <= seed_in;
         swap_ff      <= swap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign csr_ready      = 1'b1;

endmodule

### rtl/wsmr_checker.sv
// Port-level checker for the word stream multiply-rotate hash unit, with its bind statement.
// It watches the top level's ports only and uses wsmr_pkg for the register index width.
module wsmr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic [63:0]                       req_data_word,
   input logic                              req_first_word,
   input logic [31:0]                       req_message_length,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [63:0]                       rsp_hash_value,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [wsmr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input logic [63:0]                       csr_data
);
   import wsmr_pkg::*;

   logic [CSR_IDX_BITS-1:0] unused_idx;
   logic                    unused_bits;

   assign unused_idx  = csr_index;
   assign unused_bits = ^{req_data_word, csr_data, csr_valid, csr_ready, unused_idx};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("A stalled result transaction was withdrawn.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_hash_value))
      else $error("A stalled result changed its hash value.");

   a_empty_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_first_word && (req_message_length == 32'h0)
      |=> req_stall)
      else $error("An empty message did not start the final mix.");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("A result appeared without the sequencer having been busy.");

endmodule

bind word_stream_multiply_rotate_hash64_unit wsmr_checker u_wsmr_checker (.*);

### tb/sv/tb_top.sv
// Self-checking bench for word_stream_multiply_rotate_hash64_unit: directed and random message
// streams are checked against a bit-true hash predictor that is kept in this file.
// It depends on the RTL top level and on wsmr_pkg for the register index constants.
module tb_top;
   import wsmr_pkg::*;

   localparam logic [63:0] K_MUL_A = 64'h3C79AC492BA7B653;
   localparam logic [63:0] K_MUL_B = 64'h1C69B3F74AC4AE35;
   localparam logic [63:0] K_MUL_C = 64'hBEA225F9EB34556D;
   localparam logic [63:0] K_Q     = 64'hD1B92B09B92266DD;
   localparam logic [63:0] K_R     = 64'h9995988B72E0D285;
   localparam logic [63:0] K_S     = 64'h8FADF5E286E31587;
   localparam logic [63:0] K_T     = 64'hFCF8B405D3D0783B;
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 500;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [63:0]             req_data_word = '0;
   logic                    req_first_word = 1'b0;
   logic [31:0]             req_message_length = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [63:0]             rsp_hash_value;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [63:0]             csr_data = '0;

   logic [63:0] seed_reg = '0;
   logic        swap_reg = 1'b0;
   logic [63:0] hash_state = '0;
   logic [31:0] bytes_remaining = '0;
   logic [63:0] group_buf [0:2];
   logic [1:0]  group_count = '0;
   logic        second_group = 1'b0;
   logic [63:0] expected_hashes [$];

   int mismatch_count = 0;
   int sender_idle_pct = 31;
   int receiver_idle_pct = 81;
   int hold_requests = 0;
   int holds_granted = 0;
   int hold_left = 0;

   word_stream_multiply_rotate_hash64_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data_word(req_data_word),
      .req_first_word(req_first_word), .req_message_length(req_message_length),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hash_value(rsp_hash_value),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] rot_left(input logic [63:0] v, input int k);
      logic [127:0] t;
      t = {v, v} << k;
      return t[127:64];
   endfunction

   function automatic logic [63:0] byte_reverse(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[56 - 8*i +: 8] = v[8*i +: 8];
      end
      return r;
   endfunction

   function automatic logic [63:0] final_mix(input logic [63:0] h);
      logic [63:0] x;
      x = h ^ (h >> 27);
      x = x * K_MUL_A;
      x = x ^ (x >> 33);
      x = x * K_MUL_B;
      return x ^ (x >> 27);
   endfunction

   function automatic logic [63:0] single_fold(input logic [63:0] h, input logic [63:0] w);
      logic [63:0] m;
      logic [63:0] acc;
      m = w * K_MUL_C;
      m = m ^ (m >> 39);
      acc = h + m * K_MUL_C;
      return acc * K_MUL_C;
   endfunction

   function automatic logic [63:0] group_fold(input logic [63:0] h, input logic [63:0] a,
                                              input logic [63:0] b, input logic [63:0] c,
                                              input logic [63:0] d);
      logic [63:0] acc;
      acc = rot_left(h, 39);
      acc = (acc + (rot_left(a, 29) - c) * K_Q) * K_Q;
      acc = (acc + (rot_left(b, 29) - d) * K_R) * K_R;
      acc = (acc + (rot_left(c, 29) - b) * K_S) * K_S;
      acc = (acc + (rot_left(d, 29) - a) * K_T) * K_T;
      return acc;
   endfunction

   function automatic logic [63:0] last_bytes(input logic [63:0] w, input int n,
                                              input logic swapped);
      logic [63:0] v;
      int off;
      v = '0;
      off = 0;
      if (!swapped) begin
         return w & ((64'd1 << (8*n)) - 64'd1);
      end
      if (n >= 4) begin
         v[31:0] = {w[7:0], w[15:8], w[23:16], w[31:24]};
         off = 4;
      end
      if (n - off >= 2) begin
         v[8*off +: 16] = {w[8*off +: 8], w[8*off + 8 +: 8]};
         off = off + 2;
      end
      if (n - off >= 1) begin
         v[8*off +: 8] = w[8*off +: 8];
      end
      return v;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic message_open();
      return (bytes_remaining != 0) || (group_count != 0) || second_group;
   endfunction

   task automatic fold_word_into_hash(input logic [63:0] w, input logic first,
                                      input logic [31:0] len);
      logic [63:0] x;
      logic [63:0] len64;
      logic in_block;
      in_block = (group_count != 0) || second_group;
      if (first) begin
         len64 = {32'b0, len};
         hash_state = len64 ^ rot_left(len64, 3) ^ rot_left(len64, 47)
                    ^ seed_reg ^ rot_left(seed_reg, 23) ^ rot_left(seed_reg, 56);
         bytes_remaining = len;
         group_count = '0;
         second_group = 1'b0;
         in_block = 1'b0;
         if (len == 0) begin
            expected_hashes.push_back(final_mix(hash_state));
            return;
         end
      end else if (!in_block && bytes_remaining == 0) begin
         return;
      end
      if (!in_block && bytes_remaining >= 64) begin
         bytes_remaining = bytes_remaining - 64;
         in_block = 1'b1;
      end
      x = swap_reg ? byte_reverse(w) : w;
      if (in_block) begin
         if (group_count < 3) begin
            group_buf[group_count] = x;
            group_count = group_count + 1;
            return;
         end
         hash_state = group_fold(hash_state, group_buf[0], group_buf[1], group_buf[2], x);
         group_count = '0;
         second_group = ~second_group;
         if (!second_group && bytes_remaining == 0) begin
            expected_hashes.push_back(final_mix(hash_state));
         end
         return;
      end
      if (bytes_remaining >= 8) begin
         hash_state = single_fold(hash_state, x);
         bytes_remaining = bytes_remaining - 8;
         if (bytes_remaining == 0) begin
            expected_hashes.push_back(final_mix(hash_state));
         end
         return;
      end
      hash_state = single_fold(hash_state, last_bytes(w, int'(bytes_remaining), swap_reg));
      bytes_remaining = '0;
      expected_hashes.push_back(final_mix(hash_state));
   endtask

   task automatic send_word(input logic [63:0] word, input logic first, input logic [31:0] len);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data_word = word;
      req_first_word = first;
      req_message_length = len;
      do @(posedge clock); while (req_stall);
      fold_word_into_hash(word, first, len);
   endtask

   task automatic send_message(input logic [31:0] len, input int words);
      send_word(random_word(), 1'b1, len);
      for (int i = 1; i < words; i++) begin
         send_word(random_word(), 1'b0, $urandom);
      end
   endtask

   task automatic wait_for_hashes();
      @(negedge clock);
      req_valid = 1'b0;
      do @(posedge clock); while (expected_hashes.size() != 0);
   endtask

   task automatic write_register(input logic [CSR_IDX_BITS-1:0] index, input logic [63:0] value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_SEED) begin
         seed_reg = value;
      end else if (index == CSR_SWAP) begin
         swap_reg = value[0];
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_stray_word();
      send_word('1, 1'b0, '1);
      wait_for_hashes();
   endtask

   task automatic test_empty_message();
      send_word('1, 1'b1, 32'd0);
      wait_for_hashes();
   endtask

   task automatic test_short_messages();
      send_word('1, 1'b1, 32'd7);
      send_word('0, 1'b1, 32'd8);
      send_word(random_word(), 1'b1, 32'd13);
      send_word('1, 1'b0, '0);
      send_word(random_word(), 1'b0, '1);
      wait_for_hashes();
   endtask

   task automatic test_full_block();
      send_word('0, 1'b1, 32'd64);
      send_word('1, 1'b0, '0);
      send_word('0, 1'b0, '0);
      for (int i = 0; i < 5; i++) begin
         send_word(random_word(), 1'b0, $urandom);
      end
      wait_for_hashes();
   endtask

   task automatic test_restart();
      send_word(random_word(), 1'b1, 32'd30);
      send_word(random_word(), 1'b1, 32'd3);
      send_word(random_word(), 1'b1, '1);
      send_word(random_word(), 1'b1, 32'd0);
      wait_for_hashes();
   endtask

   task automatic test_swapped_tails();
      for (int n = 1; n < 8; n++) begin
         send_word(random_word(), 1'b1, n);
      end
      wait_for_hashes();
   endtask

   task automatic test_random_traffic(input int items);
      int sent;
      int pick;
      int words;
      logic [31:0] len;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 8 && !message_open()) begin
            send_word(random_word(), 1'b0, $urandom);
         end else if (pick < 16) begin
            len = $urandom_range(1) ? $urandom : $urandom_range(1, 300);
            words = $urandom_range(1, 12);
            send_message(len, words);
            sent = sent + words;
         end else begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               len = $urandom_range(0, 40);
            end else if (pick < 90) begin
               len = $urandom_range(41, 160);
            end else begin
               len = $urandom_range(161, 520);
            end
            words = (len == 0) ? 1 : int'((len + 7) / 8);
            send_message(len, words);
            sent = sent + words;
         end
      end
      send_message(32'd8, 1);
      wait_for_hashes();
   endtask

   task automatic test_backpressure();
      hold_requests = hold_requests + 1;
      for (int i = 0; i < 8; i++) begin
         send_message(32'd8, 1);
      end
      send_message(32'd20, 3);
      wait_for_hashes();
      send_message(32'd72, 9);
      wait_for_hashes();
   endtask

   always @(negedge clock) begin
      if (hold_requests != holds_granted) begin
         holds_granted = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      logic [63:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hashes.size() == 0) begin
            $error("hash_value: none expected, actual %h", rsp_hash_value);
            mismatch_count++;
         end else begin
            want = expected_hashes.pop_front();
            if (rsp_hash_value !== want) begin
               $error("hash_value: expected %h, actual %h", want, rsp_hash_value);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_stray_word();
      test_empty_message();
      test_short_messages();
      test_full_block();
      test_restart();

      write_register(CSR_SEED, '1);
      write_register(CSR_SWAP, 64'd1);
      test_swapped_tails();

      write_register(CSR_SEED, random_word());
      write_register(CSR_SWAP, 64'd0);
      test_random_traffic(233);

      write_register(CSR_SEED, 64'd0);
      write_register(CSR_SWAP, 64'd1);
      sender_idle_pct = 81;
      receiver_idle_pct = 31;
      test_random_traffic(233);

      write_register(CSR_SEED, random_word());
      write_register(CSR_SWAP, 64'($urandom_range(1)));
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_traffic(234);
      test_backpressure();

      wait_for_hashes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

### word_stream_multiply_rotate_hash64_unit.f
rtl/wsmr_pkg.sv
rtl/wsmr_mul.sv
rtl/word_stream_multiply_rotate_hash64_unit.sv
rtl/wsmr_checker.sv
tb/sv/tb_top.sv
